FILE: rtl/i2cms_pkg.sv
// i2cms_pkg: shared types, command codes and helpers for the i2c master bit sequencer
// no dependencies; imported by every module of the block

package i2cms_pkg;

    localparam int ACTION_W = 4;
    localparam int BYTE_W   = 8;
    localparam int PHASE_W  = 6;
    localparam int COUNT_W  = 4;

    localparam logic [COUNT_W-1:0] RECOVERY_COUNT_RST = 4'd9;

    // input action codes
    localparam logic [ACTION_W-1:0] ACT_TICK    = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_START   = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_STOP    = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE   = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_READ    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_ACK     = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_NACK    = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_WAITACK = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_RECOVER = 4'd8;

    // last phases of the fixed-length commands
    localparam logic [PHASE_W-1:0] PH_WRITE_LAST = 6'd23;
    localparam logic [PHASE_W-1:0] PH_READ_LAST  = 6'd16;

    typedef enum logic [8:0] {
        CMD_IDLE    = 9'b000000001,
        CMD_START   = 9'b000000010,
        CMD_STOP    = 9'b000000100,
        CMD_WRITE   = 9'b000001000,
        CMD_READ    = 9'b000010000,
        CMD_ACK     = 9'b000100000,
        CMD_NACK    = 9'b001000000,
        CMD_WAITACK = 9'b010000000,
        CMD_RECOVER = 9'b100000000
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   tx_byte;
        logic                sda_in;
    } tick_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_drive_low;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_level;
        logic              rejected;
    } result_t;

    function automatic cmd_t action_to_cmd(input logic [ACTION_W-1:0] action);
        cmd_t cmd;
        case (action)
            ACT_START:   cmd = CMD_START;
            ACT_STOP:    cmd = CMD_STOP;
            ACT_WRITE:   cmd = CMD_WRITE;
            ACT_READ:    cmd = CMD_READ;
            ACT_ACK:     cmd = CMD_ACK;
            ACT_NACK:    cmd = CMD_NACK;
            ACT_WAITACK: cmd = CMD_WAITACK;
            ACT_RECOVER: cmd = CMD_RECOVER;
            default:     cmd = CMD_IDLE;
        endcase
        return cmd;
    endfunction

endpackage

FILE: rtl/i2cms_in_reg.sv
// i2cms_in_reg: input register stage holding one tick transaction
// depends on i2cms_pkg

module i2cms_in_reg import i2cms_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  tick_t s_tick,
    output logic  tick_valid,
    input  logic  tick_take,
    output tick_t tick
);

    logic  valid_reg;
    logic  valid_next;
    tick_t tick_reg;

    assign s_ready    = !valid_reg || tick_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !tick_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            tick_reg <= s_tick;
        end
    end

    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

endmodule

FILE: rtl/i2cms_engine.sv
// i2cms_engine: command state, line state and per-tick sequencing logic
// depends on i2cms_pkg

module i2cms_engine import i2cms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic               advance,
    input  tick_t              tick,
    output result_t            res
);

    cmd_t               cmd_reg, cmd_next, cmd_eff;
    logic [PHASE_W-1:0] phase_reg, phase_next, p_eff;
    logic [1:0]         sub_reg, sub_next, sub_eff;
    logic [BYTE_W-1:0]  shift_reg, shift_next, shift_eff;
    logic [BYTE_W-1:0]  rcv_reg, rcv_next;
    logic               ack_reg, ack_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic [COUNT_W-1:0] count_reg;

    logic               scl, sda, busy, done, rej, hold_low;
    logic [PHASE_W-1:0] pulses;
    logic [PHASE_W-1:0] tail;

    assign pulses = {1'b0, count_reg, 1'b0};
    assign tail   = p_eff - pulses;

    always_comb begin
        rej       = 1'b0;
        busy      = 1'b0;
        done      = 1'b0;
        hold_low  = 1'b0;
        scl       = scl_reg;
        sda       = sda_reg;
        cmd_eff   = cmd_reg;
        p_eff     = phase_reg;
        sub_eff   = sub_reg;
        shift_eff = shift_reg;
        rcv_next  = rcv_reg;
        ack_next  = ack_reg;

        // accept a command only when idle
        if (cmd_reg != CMD_IDLE) begin
            if (tick.action != ACT_TICK) begin
                rej = 1'b1;
            end
        end else begin
            cmd_eff = action_to_cmd(tick.action);
            if (cmd_eff != CMD_IDLE) begin
                p_eff   = '0;
                sub_eff = 2'd0;
                if (cmd_eff == CMD_WRITE) begin
                    shift_eff = tick.tx_byte;
                end else if (cmd_eff == CMD_READ) begin
                    shift_eff = '0;
                end
            end
        end
        shift_next = shift_eff;

        unique case (cmd_eff)
            CMD_IDLE: begin
            end
            CMD_START: begin
                busy = 1'b1;
                priority if (p_eff == 6'd0) begin
                    sda = 1'b0;
                end else if (p_eff == 6'd1) begin
                    scl = 1'b1;
                end else if (p_eff == 6'd2) begin
                    sda = 1'b1;
                end else begin
                    scl  = 1'b0;
                    done = 1'b1;
                end
            end
            CMD_STOP: begin
                busy = 1'b1;
                priority if (p_eff == 6'd0) begin
                    scl = 1'b0;
                end else if (p_eff == 6'd1) begin
                    sda = 1'b1;
                end else if (p_eff == 6'd2) begin
                    scl = 1'b1;
                end else begin
                    sda  = 1'b0;
                    done = 1'b1;
                end
            end
            CMD_ACK, CMD_NACK: begin
                busy = 1'b1;
                priority if (p_eff == 6'd0) begin
                    sda = (cmd_eff == CMD_ACK);
                end else if (p_eff == 6'd1) begin
                    scl = 1'b1;
                end else begin
                    scl  = 1'b0;
                    done = 1'b1;
                end
            end
            CMD_WAITACK: begin
                busy = 1'b1;
                sda  = 1'b0;
                if (p_eff == 6'd0) begin
                    scl      = 1'b1;
                    ack_next = tick.sda_in;
                end else begin
                    scl  = 1'b0;
                    done = 1'b1;
                end
            end
            CMD_WRITE: begin
                busy = 1'b1;
                priority if (sub_eff == 2'd0) begin
                    scl = 1'b0;
                end else if (sub_eff == 2'd1) begin
                    sda = !shift_eff[BYTE_W-1];
                end else begin
                    scl        = 1'b1;
                    shift_next = {shift_eff[BYTE_W-2:0], 1'b0};
                    if (p_eff >= PH_WRITE_LAST) begin
                        done     = 1'b1;
                        hold_low = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                busy = 1'b1;
                sda  = 1'b0;
                priority if (p_eff >= PH_READ_LAST) begin
                    scl      = 1'b0;
                    rcv_next = shift_eff;
                    done     = 1'b1;
                end else if (!p_eff[0]) begin
                    scl = 1'b0;
                end else begin
                    scl        = 1'b1;
                    shift_next = {shift_eff[BYTE_W-2:0], tick.sda_in};
                end
            end
            CMD_RECOVER: begin
                busy = 1'b1;
                priority if (p_eff < pulses) begin
                    sda = 1'b0;
                    scl = p_eff[0];
                end else if (tail == 6'd0) begin
                    sda = 1'b1;
                end else if (tail == 6'd1) begin
                    scl = 1'b1;
                end else if (tail == 6'd2) begin
                    sda = 1'b0;
                end else begin
                    scl  = 1'b0;
                    done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (done || !busy) begin
            cmd_next   = CMD_IDLE;
            phase_next = '0;
            sub_next   = 2'd0;
        end else begin
            cmd_next   = cmd_eff;
            phase_next = p_eff + 6'd1;
            sub_next   = (sub_eff == 2'd2) ? 2'd0 : sub_eff + 2'd1;
        end
        scl_next = hold_low ? 1'b0 : scl;
        sda_next = sda;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_IDLE;
            phase_reg <= '0;
            sub_reg   <= 2'd0;
            shift_reg <= '0;
            rcv_reg   <= '0;
            ack_reg   <= 1'b1;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b0;
        end else if (advance) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            shift_reg <= shift_next;
            rcv_reg   <= rcv_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= RECOVERY_COUNT_RST;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        res.scl_level     = scl;
        res.sda_drive_low = sda;
        res.busy_res      = busy;
        res.done_res      = done;
        res.rx_byte       = rcv_next;
        res.ack_level     = ack_next;
        res.rejected      = rej;
    end

`ifndef SYNTHESIS
    a_idle_phase_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_reg == CMD_IDLE |-> (phase_reg == '0 && sub_reg == 2'd0))
        else $error("idle with nonzero phase");

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg != 2'd3)
        else $error("sub-phase out of range");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && done |=> cmd_reg == CMD_IDLE)
        else $error("command still running after its last tick");

    a_reject_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && rej |-> busy && cmd_reg != CMD_IDLE)
        else $error("reject flagged while idle");

    a_write_hold_low: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && hold_low |=> !scl_reg)
        else $error("scl not held low after write byte");
`endif

endmodule

FILE: rtl/i2cms_out_reg.sv
// i2cms_out_reg: result register toward the m_ side
// depends on i2cms_pkg

module i2cms_out_reg import i2cms_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tick_valid,
    output logic    tick_take,
    input  result_t res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign tick_take  = tick_valid && (!valid_reg || m_ready);
    assign valid_next = tick_take || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_take) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

FILE: rtl/i2c_master_bit_sequencer.sv
// i2c_master_bit_sequencer: top level of the open-drain i2c master line sequencer
// depends on i2cms_pkg, i2cms_in_reg, i2cms_engine, i2cms_out_reg
//
// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    s_action, s_tx_byte, s_sda_in
// m_       out        m_valid / m_ready    m_scl_level .. m_rejected (one per tick)
// cfg_     in         cfg_wr_en            cfg_wr_data (recovery pulse count)
//
// one tick transaction per cycle unless the m_ side stalls; a tick's result is registered
// when the tick is taken (input register, then sequencing logic into the result register)
// aresetn is synchronous, active low; it clears the command state and both valids
// a stalled m_ side fills the result register, then the input register, then drops s_ready

module i2c_master_bit_sequencer import i2cms_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [BYTE_W-1:0]   s_tx_byte,
    input  logic                s_sda_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_scl_level,
    output logic                m_sda_drive_low,
    output logic                m_busy_res,
    output logic                m_done_res,
    output logic [BYTE_W-1:0]   m_rx_byte,
    output logic                m_ack_level,
    output logic                m_rejected
);

    tick_t   s_tick;
    tick_t   tick;
    logic    tick_valid;
    logic    tick_take;
    result_t res;
    result_t m_res;

    assign s_tick.action  = s_action;
    assign s_tick.tx_byte = s_tx_byte;
    assign s_tick.sda_in  = s_sda_in;

    i2cms_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_tick     (s_tick),
        .tick_valid (tick_valid),
        .tick_take  (tick_take),
        .tick       (tick)
    );

    i2cms_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (tick_take),
        .tick        (tick),
        .res         (res)
    );

    i2cms_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_valid (tick_valid),
        .tick_take  (tick_take),
        .res        (res),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (m_res)
    );

    assign m_scl_level     = m_res.scl_level;
    assign m_sda_drive_low = m_res.sda_drive_low;
    assign m_busy_res      = m_res.busy_res;
    assign m_done_res      = m_res.done_res;
    assign m_rx_byte       = m_res.rx_byte;
    assign m_ack_level     = m_res.ack_level;
    assign m_rejected      = m_res.rejected;

endmodule

FILE: verif/i2cms_tick_checker.sv
`timescale 1ns / 100ps
// i2cms_tick_checker: predicts the scl/sda line levels and status of every tick transaction
// and compares them with the m_ side results of i2c_master_bit_sequencer
// depends on i2cms_pkg for widths, action codes and the result layout

module i2cms_tick_checker import i2cms_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [BYTE_W-1:0]   s_tx_byte,
    input  logic                s_sda_in,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_scl_level,
    input  logic                m_sda_drive_low,
    input  logic                m_busy_res,
    input  logic                m_done_res,
    input  logic [BYTE_W-1:0]   m_rx_byte,
    input  logic                m_ack_level,
    input  logic                m_rejected,
    output int                  mismatches,
    output int                  outstanding
);

    result_t expected_lines[$];
    result_t got_line;
    result_t want_line;
    int      result_index;

    logic [COUNT_W-1:0]  pulse_count;
    logic [ACTION_W-1:0] run_cmd;
    logic [PHASE_W-1:0]  phase;
    logic [BYTE_W-1:0]   shifter;
    logic [BYTE_W-1:0]   rx_hold;
    logic                ack_hold;
    logic                line_scl;
    logic                line_sda_low;

    function automatic result_t advance_line_state(input logic [ACTION_W-1:0] action,
                                                   input logic [BYTE_W-1:0] tx,
                                                   input logic sda_in);
        result_t            r;
        logic               scl;
        logic               sda;
        logic               done_now;
        logic               park_low;
        logic [PHASE_W-1:0] p;
        logic [PHASE_W-1:0] t;
        logic [PHASE_W-1:0] pulse_ticks;
        r = '0;
        scl = line_scl;
        sda = line_sda_low;
        done_now = 1'b0;
        park_low = 1'b0;
        if (run_cmd != ACT_TICK) begin
            if (action != ACT_TICK) r.rejected = 1'b1;
        end else if (action >= ACT_START && action <= ACT_RECOVER) begin
            run_cmd = action;
            phase = '0;
            if (action == ACT_WRITE) shifter = tx;
            else if (action == ACT_READ) shifter = '0;
        end
        if (run_cmd != ACT_TICK) begin
            p = phase;
            r.busy_res = 1'b1;
            case (run_cmd)
                ACT_START: begin
                    if (p == 0) sda = 1'b0;
                    else if (p == 1) scl = 1'b1;
                    else if (p == 2) sda = 1'b1;
                    else begin
                        scl = 1'b0;
                        done_now = 1'b1;
                    end
                end
                ACT_STOP: begin
                    if (p == 0) scl = 1'b0;
                    else if (p == 1) sda = 1'b1;
                    else if (p == 2) scl = 1'b1;
                    else begin
                        sda = 1'b0;
                        done_now = 1'b1;
                    end
                end
                ACT_ACK, ACT_NACK: begin
                    if (p == 0) sda = (run_cmd == ACT_ACK);
                    else if (p == 1) scl = 1'b1;
                    else begin
                        scl = 1'b0;
                        done_now = 1'b1;
                    end
                end
                ACT_WAITACK: begin
                    sda = 1'b0;
                    if (p == 0) begin
                        scl = 1'b1;
                        ack_hold = sda_in;
                    end else begin
                        scl = 1'b0;
                        done_now = 1'b1;
                    end
                end
                ACT_WRITE: begin
                    if (p % 3 == 0) scl = 1'b0;
                    else if (p % 3 == 1) sda = ~shifter[BYTE_W-1];
                    else begin
                        scl = 1'b1;
                        shifter = shifter << 1;
                        if (p >= PH_WRITE_LAST) begin
                            done_now = 1'b1;
                            park_low = 1'b1;
                        end
                    end
                end
                ACT_READ: begin
                    sda = 1'b0;
                    if (p >= PH_READ_LAST) begin
                        scl = 1'b0;
                        rx_hold = shifter;
                        done_now = 1'b1;
                    end else if (!p[0]) scl = 1'b0;
                    else begin
                        scl = 1'b1;
                        shifter = {shifter[BYTE_W-2:0], sda_in};
                    end
                end
                ACT_RECOVER: begin
                    pulse_ticks = {1'b0, pulse_count, 1'b0};
                    if (p < pulse_ticks) begin
                        sda = 1'b0;
                        scl = p[0];
                    end else begin
                        t = p - pulse_ticks;
                        if (t == 0) sda = 1'b1;
                        else if (t == 1) scl = 1'b1;
                        else if (t == 2) sda = 1'b0;
                        else begin
                            scl = 1'b0;
                            done_now = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (done_now) begin
                run_cmd = ACT_TICK;
                phase = '0;
            end else begin
                phase = phase + 1'b1;
            end
        end
        line_scl = park_low ? 1'b0 : scl;
        line_sda_low = sda;
        r.scl_level = scl;
        r.sda_drive_low = sda;
        r.done_res = done_now;
        r.rx_byte = rx_hold;
        r.ack_level = ack_hold;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("error at %0t, result %0d: %s", $time, result_index, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pulse_count = RECOVERY_COUNT_RST;
            run_cmd = ACT_TICK;
            phase = '0;
            shifter = '0;
            rx_hold = '0;
            ack_hold = 1'b1;
            line_scl = 1'b1;
            line_sda_low = 1'b0;
            result_index = 0;
            expected_lines.delete();
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) pulse_count = cfg_wr_data;
            if (s_valid && s_ready)
                expected_lines.push_back(advance_line_state(s_action, s_tx_byte, s_sda_in));
            if (m_valid && m_ready) begin
                got_line = '{m_scl_level, m_sda_drive_low, m_busy_res, m_done_res,
                             m_rx_byte, m_ack_level, m_rejected};
                if (expected_lines.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want_line = expected_lines.pop_front();
                    compare_field("scl_level", got_line.scl_level, want_line.scl_level);
                    compare_field("sda_drive_low", got_line.sda_drive_low,
                                  want_line.sda_drive_low);
                    compare_field("busy_res", got_line.busy_res, want_line.busy_res);
                    compare_field("done_res", got_line.done_res, want_line.done_res);
                    compare_field("rx_byte", got_line.rx_byte, want_line.rx_byte);
                    compare_field("ack_level", got_line.ack_level, want_line.ack_level);
                    compare_field("rejected", got_line.rejected, want_line.rejected);
                end
                result_index++;
            end
            outstanding <= expected_lines.size();
        end
    end

endmodule

FILE: verif/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 100ps
// i2c_master_bit_sequencer_tb: drives tick transactions, pulse count writes and m_ side stalls
// into i2c_master_bit_sequencer; checking is done by i2cms_tick_checker beside it
// depends on i2cms_pkg, i2cms_tick_checker and the rtl of the block

module i2c_master_bit_sequencer_tb;
    import i2cms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_LONG     = 3;

    // action codes with no command behind them
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_MIN = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNKNOWN_MAX = 4'd15;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [COUNT_W-1:0]  cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action = ACT_TICK;
    logic [BYTE_W-1:0]   s_tx_byte = '0;
    logic                s_sda_in = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_scl_level;
    logic                m_sda_drive_low;
    logic                m_busy_res;
    logic                m_done_res;
    logic [BYTE_W-1:0]   m_rx_byte;
    logic                m_ack_level;
    logic                m_rejected;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int burst_left = 0;
    int pulse_setting = int'(RECOVERY_COUNT_RST);
    int stall_mode = RX_FREE;
    int stall_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    i2c_master_bit_sequencer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_tx_byte       (s_tx_byte),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_level     (m_scl_level),
        .m_sda_drive_low (m_sda_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_rx_byte       (m_rx_byte),
        .m_ack_level     (m_ack_level),
        .m_rejected      (m_rejected)
    );

    i2cms_tick_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_tx_byte       (s_tx_byte),
        .s_sda_in        (s_sda_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_scl_level     (m_scl_level),
        .m_sda_drive_low (m_sda_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_rx_byte       (m_rx_byte),
        .m_ack_level     (m_ack_level),
        .m_rejected      (m_rejected),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stall pattern, switching to a randomly chosen mode when each run of a mode ends
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(RX_FREE, RX_LONG);
            stall_left <= $urandom_range(40, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            RX_FREE:     m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= ($urandom_range(0, 2) != 0);
            RX_PERIODIC: m_ready <= (stall_left % 6) > 1;
            default:     m_ready <= (stall_left % 16) < 4;
        endcase
    end

    function automatic int cmd_ticks(input logic [ACTION_W-1:0] action);
        case (action)
            ACT_START, ACT_STOP: return 4;
            ACT_ACK, ACT_NACK:   return 3;
            ACT_WAITACK:         return 2;
            ACT_WRITE:           return int'(PH_WRITE_LAST) + 1;
            ACT_READ:            return int'(PH_READ_LAST) + 1;
            ACT_RECOVER:         return 2 * pulse_setting + 4;
            default:             return 1;
        endcase
    endfunction

    task automatic send_tick(input logic [ACTION_W-1:0] action, input logic [BYTE_W-1:0] tx,
                             input logic sda);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_action <= action;
        s_tx_byte <= tx;
        s_sda_in <= sda;
        do @(posedge aclk); while (!s_ready);
    endtask

    // first tick carries the command, the rest keep the bus clocked; rd supplies read data
    task automatic run_command(input logic [ACTION_W-1:0] action, input logic [BYTE_W-1:0] tx,
                               input logic [BYTE_W-1:0] rd, input bit noisy);
        int                  span;
        int                  k;
        logic                sda;
        logic [ACTION_W-1:0] act;
        span = cmd_ticks(action);
        send_tick(action, tx, rd[BYTE_W-1]);
        for (k = 1; k < span; k++) begin
            if (action == ACT_READ && k % 2 == 1 && k < int'(PH_READ_LAST)) sda = rd[7 - k / 2];
            else sda = 1'($urandom_range(0, 1));
            if (noisy && $urandom_range(0, 7) == 0)
                act = ACTION_W'($urandom_range(ACT_START, ACT_UNKNOWN_MAX));
            else act = ACT_TICK;
            send_tick(act, BYTE_W'($urandom), sda);
        end
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_pulse_count(input int count);
        wait_quiet();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= COUNT_W'(count);
        pulse_setting = count;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_traffic(input int n_ticks);
        int                  sent;
        int                  idle_len;
        logic [ACTION_W-1:0] act;
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(0, 9) == 0) begin
                idle_len = $urandom_range(1, 4);
                repeat (idle_len) begin
                    if ($urandom_range(0, 1)) act = ACT_TICK;
                    else act = ACTION_W'($urandom_range(ACT_UNKNOWN_MIN, ACT_UNKNOWN_MAX));
                    send_tick(act, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
                end
                sent += idle_len;
            end else begin
                act = ACTION_W'($urandom_range(ACT_START, ACT_RECOVER));
                run_command(act, BYTE_W'($urandom), BYTE_W'($urandom), 1'b1);
                sent += cmd_ticks(act);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_command(ACT_START, 8'h00, 8'h00, 1'b0);
        run_command(ACT_WRITE, 8'hFF, 8'h00, 1'b0);
        run_command(ACT_WAITACK, 8'h00, 8'h00, 1'b0);
        run_command(ACT_WRITE, 8'h00, 8'hFF, 1'b0);
        run_command(ACT_WAITACK, 8'h00, 8'h80, 1'b0);
        run_command(ACT_WRITE, 8'hA5, 8'h00, 1'b0);
        run_command(ACT_READ, 8'h00, 8'hFF, 1'b0);
        run_command(ACT_READ, 8'hFF, 8'h00, 1'b0);
        run_command(ACT_READ, 8'h00, 8'h5A, 1'b0);
        run_command(ACT_ACK, 8'h00, 8'h00, 1'b0);
        run_command(ACT_NACK, 8'h00, 8'h00, 1'b0);
        send_tick(ACT_TICK, 8'h00, 1'b0);
        send_tick(ACT_UNKNOWN_MIN, 8'hFF, 1'b1);
        send_tick(ACT_UNKNOWN_MAX, 8'h00, 1'b0);
        run_command(ACT_STOP, 8'h00, 8'h00, 1'b0);
        // commands arriving mid start are rejected
        send_tick(ACT_START, 8'h00, 1'b0);
        send_tick(ACT_RECOVER, 8'h00, 1'b0);
        send_tick(ACT_UNKNOWN_MAX, 8'hFF, 1'b1);
        send_tick(ACT_TICK, 8'h00, 1'b0);
        run_command(ACT_RECOVER, 8'h00, 8'h00, 1'b0);

        set_pulse_count(0);
        run_command(ACT_RECOVER, 8'h00, 8'h00, 1'b0);
        set_pulse_count(15);
        run_command(ACT_RECOVER, 8'h00, 8'h00, 1'b0);
        set_pulse_count(1);
        run_command(ACT_RECOVER, 8'h00, 8'h00, 1'b0);

        set_pulse_count(0);
        random_traffic(110);
        set_pulse_count(15);
        random_traffic(110);
        set_pulse_count($urandom_range(1, 14));
        random_traffic(110);
        set_pulse_count(int'(RECOVERY_COUNT_RST));
        random_traffic(110);

        wait_quiet();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
